/* hdl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// Session affinity table package
// Shared types, codes and default sizes of the session affinity table.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned ID_BYTES_DEF = 8;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic [31:0] TIMEOUT_RST  = 32'd600000;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_SET    = 2'd1,
    REQ_TICK   = 2'd2
  } sat_req_e;

  typedef enum logic [2:0] {
    ST_FOUND         = 3'd0,
    ST_NOT_FOUND     = 3'd1,
    ST_UPDATED       = 3'd2,
    ST_CREATED       = 3'd3,
    ST_CREATED_EVICT = 3'd4,
    ST_IGNORED       = 3'd5,
    ST_TICK_DONE     = 3'd6
  } sat_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_REFRESH = 1'b1
  } sat_cfg_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_SCAN_ORD, S_SCAN_DAT, S_SCAN_CMP, S_UPD_WR,
    S_EXP_ORD, S_EXP_DAT, S_EXP_CHK, S_INS_ORD, S_INS_WR, S_BUB_RD, S_BUB_WR,
    S_DONE
  } sat_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] server_id;
    logic [7:0]  server_id_len;
    logic        create_flag;
    logic [31:0] time_ms;
  } sat_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_id;
    logic [3:0]  found_id_len;
    logic        truncated;
    logic [6:0]  expired_count;
    logic [31:0] next_wait_ms;
  } sat_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        init_wr;
    logic        ld_req;
    logic        ord_rd_k;
    logic        ord_rd_tail;
    logic        ord_rd_free;
    logic        dat_rd_ord;
    logic        k_inc;
    logic        upd_wr;
    logic        ins_wr;
    logic        bub_wr;
    logic        evict;
    logic        set_wait;
    logic        res_ld;
    sat_status_e res_status;
  } sat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       init_last;
    logic       k_last;
    logic       cnt_zero;
    logic       cnt_full;
    logic       key_match;
    logic       expired;
    logic       bub_stop;
    logic       out_free;
    logic [1:0] req_type;
    logic       create;
  } sat_sts_t;

endpackage

/* hdl/sat_stream_if.sv */
// ----------------------------------------------------------------------------
// Session affinity table stream channel
// Valid/ready channel that carries one payload per beat.
// ----------------------------------------------------------------------------
interface sat_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/session_affinity_table.sv */
// ----------------------------------------------------------------------------
// Session affinity table
// LRU table from 128-bit session keys to server ids, with timeout expiry.
// ----------------------------------------------------------------------------
// Requests arrive as beats on req_i (lookup, set or expiry tick); each gives
// exactly one response beat on rsp_o. Configuration writes (timeout and
// refresh mode) go through cfg_we_i/cfg_idx_i/cfg_data_i and must be made
// while the table is idle; the table itself does not enforce this.
// A request is taken only when the table is idle. Its latency grows with the
// work done: a recency list read, entry read and compare per live entry
// searched, a recency list read and write per position passed when an entry
// moves to the head, and a recency list read, entry read and check per entry
// checked or removed at the tail, plus dispatch and write-back. The walks
// over the recency list and entry RAMs set this latency.
// After reset the recency list is initialized, during which req_i.ready
// stays low; the table then starts empty.
// The response sits in an output register; the next request is taken and
// worked on while it waits, and only its own write-back stalls on rsp_o.
// ----------------------------------------------------------------------------
module session_affinity_table #(
  parameter int unsigned ENTRIES  = sat_pkg::ENTRIES_DEF,
  parameter int unsigned ID_BYTES = sat_pkg::ID_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sat_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sat_stream_if.sink                     req_i,
  sat_stream_if.source                   rsp_o
);
  import sat_pkg::*;

  sat_cmd_t cmd;
  sat_sts_t sts;
  sat_rsp_t rsp;
  logic     req_ready;
  logic     rsp_valid;

  sat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sat_dp #(.ENTRIES(ENTRIES), .ID_BYTES(ID_BYTES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i.payload),
    .rsp_o       (rsp),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp;

  a_no_insert_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_wr |-> !sts.cnt_full)
    else $error("insert issued with a full table");

  a_no_evict_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.evict |-> !sts.cnt_zero)
    else $error("eviction issued with an empty table");

  a_idle_no_writes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready |-> !(cmd.bub_wr || cmd.ins_wr || cmd.upd_wr || cmd.init_wr))
    else $error("table written while a request can be taken");

  a_result_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_ld |-> (!rsp_valid || rsp_o.ready))
    else $error("response overwritten before it was taken");
endmodule

/* hdl/sat_ram.sv */
// ----------------------------------------------------------------------------
// Session affinity table RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/sat_ctrl.sv */
// ----------------------------------------------------------------------------
// Session affinity table controller
// Sequences the initialization, search, update, expiry, insert and reorder passes.
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  sat_pkg::sat_sts_t sts_i,
  output sat_pkg::sat_cmd_t cmd_o
);
  import sat_pkg::*;

  sat_state_e  state_q, state_d;
  sat_status_e status_q, status_d;
  logic        force_q, force_d;

  logic        is_lookup, is_set, is_tick;
  sat_state_e  miss_state, exp_end;
  sat_status_e miss_status;

  assign is_lookup = (sts_i.req_type == REQ_LOOKUP);
  assign is_set    = (sts_i.req_type == REQ_SET);
  assign is_tick   = (sts_i.req_type == REQ_TICK);

  // What follows when the key is absent.
  always_comb begin
    if (is_lookup) begin
      miss_state  = S_DONE;
      miss_status = ST_NOT_FOUND;
    end else if (sts_i.create) begin
      miss_state  = sts_i.cnt_full ? S_EXP_ORD : S_INS_ORD;
      miss_status = sts_i.cnt_full ? ST_CREATED_EVICT : ST_CREATED;
    end else begin
      miss_state  = S_DONE;
      miss_status = ST_IGNORED;
    end
  end

  assign exp_end = is_tick ? S_DONE : S_INS_ORD;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:     if (sts_i.init_last) state_d = S_IDLE;
      S_IDLE:     if (req_valid_i) state_d = S_DISP;
      S_DISP: begin
        if (is_lookup || is_set) begin
          state_d = sts_i.cnt_zero ? miss_state : S_SCAN_ORD;
        end else if (is_tick) begin
          state_d = S_EXP_ORD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_ORD: state_d = S_SCAN_DAT;
      S_SCAN_DAT: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts_i.key_match) begin
          state_d = is_set ? S_UPD_WR : S_DONE;
        end else if (sts_i.k_last) begin
          state_d = miss_state;
        end else begin
          state_d = S_SCAN_ORD;
        end
      end
      S_UPD_WR:   state_d = S_BUB_RD;
      S_EXP_ORD:  state_d = sts_i.cnt_zero ? exp_end : S_EXP_DAT;
      S_EXP_DAT:  state_d = S_EXP_CHK;
      S_EXP_CHK:  state_d = (force_q || sts_i.expired) ? S_EXP_ORD : exp_end;
      S_INS_ORD:  state_d = S_INS_WR;
      S_INS_WR:   state_d = S_BUB_RD;
      S_BUB_RD:   state_d = S_BUB_WR;
      S_BUB_WR:   state_d = sts_i.bub_stop ? S_DONE : S_BUB_RD;
      S_DONE:     if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = status_q;
    req_ready_o      = 1'b0;
    status_d         = status_q;
    force_d          = force_q;
    unique case (state_q)
      S_INIT: cmd_o.init_wr = 1'b1;
      S_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.ld_req = req_valid_i;
      end
      S_DISP: begin
        force_d = 1'b0;
        if (is_lookup || is_set) begin
          if (sts_i.cnt_zero) begin
            status_d = miss_status;
            force_d  = (miss_status == ST_CREATED_EVICT);
          end
        end else if (is_tick) begin
          status_d = ST_TICK_DONE;
        end else begin
          status_d = ST_IGNORED;
        end
      end
      S_SCAN_ORD: cmd_o.ord_rd_k   = 1'b1;
      S_SCAN_DAT: cmd_o.dat_rd_ord = 1'b1;
      S_SCAN_CMP: begin
        if (sts_i.key_match) begin
          status_d = is_set ? ST_UPDATED : ST_FOUND;
        end else if (sts_i.k_last) begin
          status_d = miss_status;
          force_d  = (miss_status == ST_CREATED_EVICT);
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      S_UPD_WR:  cmd_o.upd_wr = 1'b1;
      S_EXP_ORD: cmd_o.ord_rd_tail = !sts_i.cnt_zero;
      S_EXP_DAT: cmd_o.dat_rd_ord = 1'b1;
      S_EXP_CHK: begin
        if (force_q || sts_i.expired) begin
          cmd_o.evict = 1'b1;
          force_d     = 1'b0;
        end else begin
          cmd_o.set_wait = is_tick;
        end
      end
      S_INS_ORD: cmd_o.ord_rd_free = 1'b1;
      S_INS_WR:  cmd_o.ins_wr = 1'b1;
      S_BUB_RD:  cmd_o.ord_rd_k = 1'b1;
      S_BUB_WR:  cmd_o.bub_wr = 1'b1;
      S_DONE:    cmd_o.res_ld = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      status_q <= ST_IGNORED;
      force_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      force_q  <= force_d;
    end
  end
endmodule

/* hdl/sat_dp.sv */
// ----------------------------------------------------------------------------
// Session affinity table datapath
// Entry storage, recency list, counters, configuration and result register.
// ----------------------------------------------------------------------------
module sat_dp #(
  parameter int unsigned ENTRIES  = sat_pkg::ENTRIES_DEF,
  parameter int unsigned ID_BYTES = sat_pkg::ID_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sat_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sat_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  sat_pkg::sat_req_t                   req_i,
  output sat_pkg::sat_rsp_t                   rsp_o,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  input  sat_pkg::sat_cmd_t                   cmd_i,
  output sat_pkg::sat_sts_t                   sts_o
);
  import sat_pkg::*;

  localparam int unsigned IW  = $clog2(ENTRIES);
  localparam int unsigned IDW = 8 * ID_BYTES;
  localparam int unsigned DW  = 128 + IDW + 4 + 32;

  // Recency list: positions below count_q hold live slots from head to tail,
  // the rest hold the free slots. It is always a permutation of all slots.
  logic [IW-1:0] k_q, k_d;
  logic [IW:0]   count_q, count_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [IW-1:0] carry_q, carry_d;
  sat_req_t      req_q;
  logic [6:0]    removed_q, removed_d;
  logic [31:0]   wait_q, wait_d;
  logic [31:0]   timeout_q;
  logic          refresh_q;
  sat_rsp_t      rsp_q;
  logic          rsp_valid_q;

  logic          ord_we, ord_re;
  logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic          dat_we;
  logic [IW-1:0] dat_waddr;
  logic [DW-1:0] dat_wdata, dat_rdata;

  logic [63:0]    rd_key_hi, rd_key_lo;
  logic [IDW-1:0] rd_id, new_id;
  logic [3:0]     rd_len, new_len;
  logic [31:0]    rd_stamp, wait_c;
  logic           trunc_c;
  logic           stored;

  assign rd_key_hi = dat_rdata[DW-1 -: 64];
  assign rd_key_lo = dat_rdata[DW-65 -: 64];
  assign rd_id     = dat_rdata[IDW+35 : 36];
  assign rd_len    = dat_rdata[35:32];
  assign rd_stamp  = dat_rdata[31:0];

  assign trunc_c = (req_q.server_id_len > 8'(ID_BYTES));
  assign new_len = trunc_c ? 4'(ID_BYTES) : req_q.server_id_len[3:0];

  always_comb begin
    for (int b = 0; b < ID_BYTES; b++) begin
      new_id[8*b +: 8] = (4'(b) < new_len) ? req_q.server_id[8*b +: 8] : 8'h00;
    end
  end

  assign wait_c = rd_stamp + timeout_q - req_q.time_ms;

  // Recency list port.
  always_comb begin
    ord_we    = cmd_i.init_wr || cmd_i.bub_wr;
    ord_waddr = k_q;
    ord_wdata = cmd_i.init_wr ? k_q : carry_q;
    ord_re    = cmd_i.ord_rd_k || cmd_i.ord_rd_tail || cmd_i.ord_rd_free;
    if (cmd_i.ord_rd_tail) begin
      ord_raddr = IW'(count_q - 1'b1);
    end else if (cmd_i.ord_rd_free) begin
      ord_raddr = count_q[IW-1:0];
    end else begin
      ord_raddr = k_q;
    end
  end

  // Entry store port.
  always_comb begin
    dat_we    = cmd_i.upd_wr || cmd_i.ins_wr;
    dat_waddr = cmd_i.ins_wr ? ord_rdata : slot_q;
    if (cmd_i.ins_wr) begin
      dat_wdata = {req_q.key_hi, req_q.key_lo, new_id, new_len, req_q.time_ms};
    end else begin
      dat_wdata = {rd_key_hi, rd_key_lo, new_id, new_len,
                   refresh_q ? req_q.time_ms : rd_stamp};
    end
  end

  sat_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  sat_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .re_i    (cmd_i.dat_rd_ord),
    .raddr_i (ord_rdata),
    .rdata_o (dat_rdata)
  );

  always_comb begin
    k_d       = k_q;
    count_d   = count_q;
    slot_d    = slot_q;
    carry_d   = carry_q;
    removed_d = removed_q;
    wait_d    = wait_q;
    if (cmd_i.ld_req || cmd_i.upd_wr || cmd_i.ins_wr) begin
      k_d = '0;
    end else if (cmd_i.init_wr || cmd_i.k_inc || cmd_i.bub_wr) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.ld_req) begin
      removed_d = '0;
      wait_d    = '0;
    end
    if (cmd_i.dat_rd_ord || cmd_i.ins_wr) begin
      slot_d = ord_rdata;
    end
    if (cmd_i.ins_wr) begin
      carry_d = ord_rdata;
      count_d = count_q + 1'b1;
    end else if (cmd_i.upd_wr) begin
      carry_d = slot_q;
    end else if (cmd_i.bub_wr) begin
      carry_d = ord_rdata;
    end
    if (cmd_i.evict) begin
      count_d   = count_q - 1'b1;
      removed_d = removed_q + 1'b1;
    end
    if (cmd_i.set_wait) begin
      wait_d = wait_c;
    end
  end

  assign stored = (cmd_i.res_status == ST_UPDATED) || (cmd_i.res_status == ST_CREATED) ||
                  (cmd_i.res_status == ST_CREATED_EVICT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      count_q     <= '0;
      timeout_q   <= TIMEOUT_RST;
      refresh_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      k_q     <= k_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIMEOUT) begin
          timeout_q <= cfg_data_i;
        end else begin
          refresh_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.res_ld) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    carry_q   <= carry_d;
    removed_q <= removed_d;
    wait_q    <= wait_d;
    if (cmd_i.ld_req) begin
      req_q <= req_i;
    end
    if (cmd_i.res_ld) begin
      rsp_q.status        <= cmd_i.res_status;
      rsp_q.found_id      <= (cmd_i.res_status == ST_FOUND) ? 64'(rd_id) : 64'd0;
      rsp_q.found_id_len  <= (cmd_i.res_status == ST_FOUND) ? rd_len : 4'd0;
      rsp_q.truncated     <= stored && trunc_c;
      rsp_q.expired_count <= removed_q;
      rsp_q.next_wait_ms  <= wait_q;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    sts_o.init_last = (k_q == IW'(ENTRIES - 1));
    sts_o.k_last    = (({1'b0, k_q} + 1'b1) == count_q);
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.cnt_full  = (count_q == (IW+1)'(ENTRIES));
    sts_o.key_match = (rd_key_hi == req_q.key_hi) && (rd_key_lo == req_q.key_lo);
    sts_o.expired   = (wait_c == 32'd0) || wait_c[31];
    sts_o.bub_stop  = (ord_rdata == slot_q);
    sts_o.out_free  = !rsp_valid_q || rsp_ready_i;
    sts_o.req_type  = req_q.req_type;
    sts_o.create    = req_q.create_flag;
  end
endmodule
